// ===== design/slcfp_pkg.sv =====
// Shared types, constants and the CRC-16/CCITT byte update for the frame parser.
// The interfaces and every module of the parser use this package by scoped names.
package slcfp_pkg;

   // Field widths of the byte stream and of the result beats.
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 16;
   localparam int CRC_W  = 16;
   localparam int KIND_W = 2;

   // Payload capacity and the width of the count of payload bytes taken.
   localparam int MAX_PAYLOAD = 256;
   localparam int TAKEN_W     = $clog2(MAX_PAYLOAD + 1);

   // CRC-16/CCITT, MSB first.
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
   localparam logic [CRC_W-1:0] CRC_SEED = 16'hFFFF;

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h55;

   // Kind of a result beat.
   typedef enum logic [KIND_W-1:0] {
      KIND_DATA  = 2'd0,
      KIND_GOOD  = 2'd1,
      KIND_BAD   = 2'd2,
      KIND_ABORT = 2'd3
   } kind_type;

   // Parse phase, one-hot.
   typedef enum logic [7:0] {
      PH_SYNC0   = 8'b0000_0001,
      PH_SYNC1   = 8'b0000_0010,
      PH_TYPE    = 8'b0000_0100,
      PH_LEN0    = 8'b0000_1000,
      PH_LEN1    = 8'b0001_0000,
      PH_PAYLOAD = 8'b0010_0000,
      PH_CRC_HI  = 8'b0100_0000,
      PH_CRC_LO  = 8'b1000_0000
   } phase_type;

   // One result from the parser to the output stage.
   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [BYTE_W-1:0] frame_type;
      logic [LEN_W-1:0]  frame_length;
   } result_type;

   // One byte of CRC-16/CCITT: eight shift steps on a 16-bit value.
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== design/slcfp_if.sv =====
// Valid/ready channel interfaces for the received bytes and the result beats.
// Widths come from slcfp_pkg.
interface slcfp_req_if;
   logic                        valid;
   logic                        ready;
   logic [slcfp_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcfp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [slcfp_pkg::KIND_W-1:0] item_kind;
   logic [slcfp_pkg::BYTE_W-1:0] payload_byte;
   logic [slcfp_pkg::BYTE_W-1:0] frame_type;
   logic [slcfp_pkg::LEN_W-1:0]  frame_length;

   modport source (output valid, output item_kind, output payload_byte,
                   output frame_type, output frame_length, input ready);
   modport sink (input valid, input item_kind, input payload_byte,
                 input frame_type, input frame_length, output ready);
endinterface

// ===== design/slcfp_parser.sv =====
// Frame parse state machine with the running CRC: one byte per step.
// Depends on slcfp_pkg for the phase encoding, result struct and CRC function.
module slcfp_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [slcfp_pkg::BYTE_W-1:0] rx_byte,
   input  logic [slcfp_pkg::BYTE_W-1:0] sync_first,
   input  logic [slcfp_pkg::BYTE_W-1:0] sync_second,
   output slcfp_pkg::result_type        result
);

   slcfp_pkg::phase_type               phase_ff, phase_in;
   logic [slcfp_pkg::BYTE_W-1:0]       type_hold_ff, type_hold_in;
   logic [slcfp_pkg::LEN_W-1:0]        length_hold_ff, length_hold_in;
   logic [slcfp_pkg::TAKEN_W-1:0]      taken_ff, taken_in;
   logic [slcfp_pkg::CRC_W-1:0]        crc_ff, crc_in;
   logic [slcfp_pkg::BYTE_W-1:0]       crc_high_ff, crc_high_in;
   logic [slcfp_pkg::TAKEN_W-1:0]      taken_inc;
   logic [slcfp_pkg::CRC_W-1:0]        crc_trailer;

   assign taken_inc   = taken_ff + 1'b1;
   assign crc_trailer = {crc_high_ff, rx_byte};

   // Next state and result for the byte at the parser input.
   always_comb begin
      phase_in       = phase_ff;
      type_hold_in   = type_hold_ff;
      length_hold_in = length_hold_ff;
      taken_in       = taken_ff;
      crc_in         = crc_ff;
      crc_high_in    = crc_high_ff;

      result.valid        = 1'b0;
      result.kind         = slcfp_pkg::KIND_DATA;
      result.payload_byte = '0;
      result.frame_type   = type_hold_ff;
      result.frame_length = length_hold_ff;

      unique case (phase_ff)
         slcfp_pkg::PH_SYNC0: begin
            if (rx_byte == sync_first) begin
               phase_in = slcfp_pkg::PH_SYNC1;
            end
         end
         slcfp_pkg::PH_SYNC1: begin
            phase_in = (rx_byte == sync_second) ? slcfp_pkg::PH_TYPE : slcfp_pkg::PH_SYNC0;
         end
         slcfp_pkg::PH_TYPE: begin
            type_hold_in = rx_byte;
            phase_in     = slcfp_pkg::PH_LEN0;
         end
         slcfp_pkg::PH_LEN0: begin
            length_hold_in = {{(slcfp_pkg::LEN_W-slcfp_pkg::BYTE_W){1'b0}}, rx_byte};
            phase_in       = slcfp_pkg::PH_LEN1;
         end
         slcfp_pkg::PH_LEN1: begin
            // Length is little-endian; an empty frame skips to the trailer.
            length_hold_in = {rx_byte, length_hold_ff[slcfp_pkg::BYTE_W-1:0]};
            taken_in       = '0;
            crc_in         = slcfp_pkg::CRC_SEED;
            phase_in       = (length_hold_in != '0) ? slcfp_pkg::PH_PAYLOAD
                                                    : slcfp_pkg::PH_CRC_HI;
         end
         slcfp_pkg::PH_PAYLOAD: begin
            result.valid = 1'b1;
            if (taken_ff < slcfp_pkg::TAKEN_W'(slcfp_pkg::MAX_PAYLOAD)) begin
               taken_in            = taken_inc;
               crc_in              = slcfp_pkg::crc_byte(crc_ff, rx_byte);
               result.payload_byte = rx_byte;
               if (slcfp_pkg::LEN_W'(taken_inc) >= length_hold_ff) begin
                  phase_in = slcfp_pkg::PH_CRC_HI;
               end
            end else begin
               // Overflow: the byte is dropped and the frame is abandoned.
               result.kind    = slcfp_pkg::KIND_ABORT;
               phase_in       = slcfp_pkg::PH_SYNC0;
               type_hold_in   = '0;
               length_hold_in = '0;
               taken_in       = '0;
               crc_in         = slcfp_pkg::CRC_SEED;
               crc_high_in    = '0;
            end
         end
         slcfp_pkg::PH_CRC_HI: begin
            crc_high_in = rx_byte;
            phase_in    = slcfp_pkg::PH_CRC_LO;
         end
         slcfp_pkg::PH_CRC_LO: begin
            // Big-endian trailer against the running CRC, then back to hunting.
            result.valid   = 1'b1;
            result.kind    = (crc_trailer == crc_ff) ? slcfp_pkg::KIND_GOOD
                                                     : slcfp_pkg::KIND_BAD;
            phase_in       = slcfp_pkg::PH_SYNC0;
            type_hold_in   = '0;
            length_hold_in = '0;
            taken_in       = '0;
            crc_in         = slcfp_pkg::CRC_SEED;
            crc_high_in    = '0;
         end
         default: begin
            phase_in       = slcfp_pkg::PH_SYNC0;
            type_hold_in   = '0;
            length_hold_in = '0;
            taken_in       = '0;
            crc_in         = slcfp_pkg::CRC_SEED;
            crc_high_in    = '0;
         end
      endcase
   end

   // State registers advance only when a byte is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= slcfp_pkg::PH_SYNC0;
         type_hold_ff   <= '0;
         length_hold_ff <= '0;
         taken_ff       <= '0;
         crc_ff         <= slcfp_pkg::CRC_SEED;
         crc_high_ff    <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         type_hold_ff   <= type_hold_in;
         length_hold_ff <= length_hold_in;
         taken_ff       <= taken_in;
         crc_ff         <= crc_in;
         crc_high_ff    <= crc_high_in;
      end
   end

   // A frame end or abort always returns the parser to hunting.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      step && result.valid && (result.kind != slcfp_pkg::KIND_DATA)
      |=> (phase_ff == slcfp_pkg::PH_SYNC0) && (crc_ff == slcfp_pkg::CRC_SEED))
      else $error("parser did not return to hunting after frame end");

   // The payload count never passes the capacity.
   a_taken_bound: assert property (@(posedge clock) disable iff (reset)
      taken_ff <= slcfp_pkg::TAKEN_W'(slcfp_pkg::MAX_PAYLOAD))
      else $error("payload count beyond capacity");

   // The payload phase is only entered for a nonzero declared length.
   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == slcfp_pkg::PH_PAYLOAD) |-> (length_hold_ff != '0))
      else $error("payload phase with zero length");

endmodule

// ===== design/slcfp_out_stage.sv =====
// Result register with a skid entry in front of the result channel.
// Depends on slcfp_pkg for the result struct and slcfp_if for the channel.
module slcfp_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  slcfp_pkg::result_type push_data,
   output logic                  room,
   slcfp_rsp_if.source           rsp
);

   logic                  main_valid_ff, main_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   slcfp_pkg::result_type main_ff, main_in;
   slcfp_pkg::result_type skid_ff, skid_in;
   logic                  pop;

   assign pop  = main_valid_ff && rsp.ready;
   assign room = !skid_valid_ff;

   // Main register refills from the skid entry first, then from a new push.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid        = main_valid_ff;
   assign rsp.item_kind    = main_ff.kind;
   assign rsp.payload_byte = main_ff.payload_byte;
   assign rsp.frame_type   = main_ff.frame_type;
   assign rsp.frame_length = main_ff.frame_length;

   // The skid entry is only occupied behind a full main register.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds a beat while main register is empty");

   // Nothing is pushed while the skid entry is occupied.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("push into a full output stage");

   // A stalled beat with a waiting skid entry keeps both entries.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp.ready |=> skid_valid_ff && main_valid_ff)
      else $error("output stage lost a beat under stall");

endmodule

// ===== design/sync_length_crc_frame_parser.sv =====
// Top level of the sync/length/CRC-16 frame parser: input register, parser and
// output stage. Depends on slcfp_pkg, slcfp_if, slcfp_parser and slcfp_out_stage.
//
// Usage:
//   req carries one received byte per beat (rx_byte). The parser hunts for the
//   two sync bytes, reads a type byte and a little-endian 16-bit length, passes
//   each payload byte out as a beat of kind 0 and checks a big-endian CRC-16
//   trailer, ending the frame with a beat of kind 1 (good) or 2 (bad). A payload
//   byte beyond capacity is dropped and gives a beat of kind 3.
//   rsp carries at most one result beat per accepted byte.
//   csr_write_enable with csr_index 0 or 1 sets the first or second sync byte;
//   other indexes are ignored. Write only while the parser is idle.
//
//   A byte waits in the input register until the output stage has room; its result
//   then goes to the result register (or the skid entry), from which rsp takes it.
//   Throughput: one byte per cycle while the output stage has room, set by the
//   byte-wide CRC update and phase transition, both done combinationally.
//   Reset (synchronous) clears the frame state, restores the sync bytes to
//   0xAA and 0x55 and empties all stages. When rsp stalls, a skid entry takes
//   one more result; req.ready drops only once the skid entry is occupied.
module sync_length_crc_frame_parser (
   input  logic                              clock,
   input  logic                              reset,
   slcfp_req_if.sink                         req,
   slcfp_rsp_if.source                       rsp,
   input  logic                              csr_write_enable,
   input  logic [slcfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slcfp_pkg::BYTE_W-1:0]      csr_write_data
);

   logic [slcfp_pkg::BYTE_W-1:0] sync_first_val_ff;
   logic [slcfp_pkg::BYTE_W-1:0] sync_second_ff;
   logic                         in_valid_ff, in_valid_in;
   logic [slcfp_pkg::BYTE_W-1:0] in_byte_ff;
   logic                         room;
   logic                         advance;
   logic                         req_accept;
   slcfp_pkg::result_type        result;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_val_ff <= slcfp_pkg::SYNC_FIRST_RESET;
         sync_second_ff    <= slcfp_pkg::SYNC_SECOND_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            slcfp_pkg::CSR_SYNC_FIRST: begin
               sync_first_val_ff <= csr_write_data;
            end
            slcfp_pkg::CSR_SYNC_SECOND: begin
               sync_second_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Input register: one byte waits here until the output stage has room.
   assign advance    = in_valid_ff && room;
   assign req.ready  = !in_valid_ff || room;
   assign req_accept = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req.rx_byte;
      end
   end

   slcfp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (in_byte_ff),
      .sync_first  (sync_first_val_ff),
      .sync_second (sync_second_ff),
      .result      (result)
   );

   slcfp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && result.valid),
      .push_data (result),
      .room      (room),
      .rsp       (rsp)
   );

endmodule

// ===== bench/slcfp_frame_checker.sv =====
// Bench package with the CRC-16/CCITT byte step, and the checker that watches the parser's
// channels, predicts every result beat and compares it. Depends on slcfp_pkg and slcfp_if.
package slcfp_bench_pkg;

   // Bit-serial CRC-16/CCITT update over one byte, MSB first.
   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] r;
      logic        feedback;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = r[15] ^ data[i];
         r = {r[14:0], 1'b0};
         if (feedback) begin
            r = r ^ slcfp_pkg::CRC_POLY;
         end
      end
      return r;
   endfunction

endpackage

module slcfp_frame_checker (
   input  logic                              clock,
   input  logic                              reset,
   slcfp_req_if                              req,
   slcfp_rsp_if                              rsp,
   input  logic                              csr_write_enable,
   input  logic [slcfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slcfp_pkg::BYTE_W-1:0]      csr_write_data,
   output int                                failures,
   output int                                pending
);
   import slcfp_pkg::*;
   import slcfp_bench_pkg::*;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [BYTE_W-1:0] frame_type;
      logic [LEN_W-1:0]  frame_length;
   } beat_type;

   beat_type expected_beats[$];

   // Shadow copy of the sync registers and of the frame state.
   logic [BYTE_W-1:0]  sync_first_reg;
   logic [BYTE_W-1:0]  sync_second_reg;
   phase_type          parse_phase;
   logic [BYTE_W-1:0]  type_hold;
   logic [LEN_W-1:0]   length_hold;
   logic [TAKEN_W-1:0] bytes_taken;
   logic [CRC_W-1:0]   crc_running;
   logic [BYTE_W-1:0]  crc_high_hold;

   function automatic void clear_frame();
      parse_phase   = PH_SYNC0;
      type_hold     = '0;
      length_hold   = '0;
      bytes_taken   = '0;
      crc_running   = CRC_SEED;
      crc_high_hold = '0;
   endfunction

   function automatic void push_beat(input kind_type kind, input logic [BYTE_W-1:0] data);
      beat_type b;
      b.kind         = kind;
      b.payload_byte = data;
      b.frame_type   = type_hold;
      b.frame_length = length_hold;
      expected_beats.push_back(b);
   endfunction

   // Advance the frame state by one received byte and queue the beat it causes, if any.
   function automatic void predict_byte(input logic [BYTE_W-1:0] data);
      case (parse_phase)
         PH_SYNC0: begin
            if (data == sync_first_reg) begin
               parse_phase = PH_SYNC1;
            end
         end
         PH_SYNC1: begin
            // A mismatch goes back to hunting without reusing the byte.
            parse_phase = (data == sync_second_reg) ? PH_TYPE : PH_SYNC0;
         end
         PH_TYPE: begin
            type_hold   = data;
            parse_phase = PH_LEN0;
         end
         PH_LEN0: begin
            length_hold = {8'h00, data};
            parse_phase = PH_LEN1;
         end
         PH_LEN1: begin
            length_hold[15:8] = data;
            bytes_taken       = '0;
            crc_running       = CRC_SEED;
            parse_phase       = (length_hold != '0) ? PH_PAYLOAD : PH_CRC_HI;
         end
         PH_PAYLOAD: begin
            if (bytes_taken < MAX_PAYLOAD) begin
               bytes_taken = bytes_taken + 1'b1;
               crc_running = crc_next(crc_running, data);
               if (bytes_taken >= length_hold) begin
                  parse_phase = PH_CRC_HI;
               end
               push_beat(KIND_DATA, data);
            end else begin
               // Overflow: the byte is dropped and the frame is abandoned.
               push_beat(KIND_ABORT, '0);
               clear_frame();
            end
         end
         PH_CRC_HI: begin
            crc_high_hold = data;
            parse_phase   = PH_CRC_LO;
         end
         default: begin
            push_beat(({crc_high_hold, data} == crc_running) ? KIND_GOOD : KIND_BAD, '0);
            clear_frame();
         end
      endcase
   endfunction

   function automatic void note_failure();
      failures++;
   endfunction

   // Compare one accepted result beat with the oldest expectation.
   function automatic void check_beat();
      beat_type want;
      if (expected_beats.size() == 0) begin
         $error("unexpected result beat: item_kind %0d payload_byte 0x%02h",
                rsp.item_kind, rsp.payload_byte);
         note_failure();
      end else begin
         want = expected_beats.pop_front();
         if (rsp.item_kind !== want.kind) begin
            $error("item_kind: expected %0d, actual %0d", want.kind, rsp.item_kind);
            note_failure();
         end
         if (rsp.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected 0x%02h, actual 0x%02h",
                   want.payload_byte, rsp.payload_byte);
            note_failure();
         end
         if (rsp.frame_type !== want.frame_type) begin
            $error("frame_type: expected 0x%02h, actual 0x%02h",
                   want.frame_type, rsp.frame_type);
            note_failure();
         end
         if (rsp.frame_length !== want.frame_length) begin
            $error("frame_length: expected 0x%04h, actual 0x%04h",
                   want.frame_length, rsp.frame_length);
            note_failure();
         end
      end
   endfunction

   // Results are compared before the byte of the same edge is predicted, and a register
   // write takes effect for the byte after it.
   always @(posedge clock) begin
      if (reset) begin
         sync_first_reg  = SYNC_FIRST_RESET;
         sync_second_reg = SYNC_SECOND_RESET;
         clear_frame();
         expected_beats.delete();
      end else begin
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            check_beat();
         end
         if (req.valid === 1'b1 && req.ready === 1'b1) begin
            predict_byte(req.rx_byte);
         end
         if (csr_write_enable === 1'b1) begin
            case (csr_index)
               CSR_SYNC_FIRST:  sync_first_reg  = csr_write_data;
               CSR_SYNC_SECOND: sync_second_reg = csr_write_data;
               default: ;
            endcase
         end
      end
      pending = expected_beats.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// Top of the frame parser bench: clock, reset, byte and register stimulus, and the verdict.
// Depends on slcfp_pkg, slcfp_if, the parser and the checker with its bench package.
module tb_top;
   import slcfp_pkg::*;
   import slcfp_bench_pkg::*;

   // Register indexes that decode to nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   // Settle wait over the two stages plus margin, the long receiver hold-off, bytes per phase, run limit.
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int PHASE_BYTES     = 310;
   localparam int RUN_LIMIT       = 4_000_000;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [BYTE_W-1:0]      csr_write_data;
   int                     check_failures;
   int                     beats_pending;
   int                     send_idle_pct;
   int                     recv_idle_pct;
   bit                     hold_off_request;
   int                     sent_bytes;
   logic [BYTE_W-1:0]      sync_first_val;
   logic [BYTE_W-1:0]      sync_second_val;

   slcfp_req_if req_ch ();
   slcfp_rsp_if rsp_ch ();

   sync_length_crc_frame_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   slcfp_frame_checker parser_check (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failures         (check_failures),
      .pending          (beats_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result receiver: random back-pressure, or one long hold-off on request.
   initial begin : receiver
      int held;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            for (held = 1; held < HOLD_OFF_CYCLES; held++) begin
               @(negedge clock);
            end
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("** sync_length_crc_frame_parser: FAILED **");
      $finish;
   end

   // Offer one byte, with random idle cycles first, and wait for its handshake.
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sent_bytes++;
   endtask

   // Whole frame with random payload. Lengths beyond capacity send one byte past it and
   // no trailer, since the parser abandons the frame there.
   task automatic send_frame(input logic [BYTE_W-1:0] type_byte, input logic [LEN_W-1:0] length,
                             input bit corrupt);
      logic [CRC_W-1:0]  crc;
      logic [BYTE_W-1:0] data;
      int                count;
      crc   = CRC_SEED;
      count = (length > MAX_PAYLOAD) ? MAX_PAYLOAD + 1 : int'(length);
      send_byte(sync_first_val);
      send_byte(sync_second_val);
      send_byte(type_byte);
      send_byte(length[7:0]);
      send_byte(length[15:8]);
      for (int i = 0; i < count; i++) begin
         data = 8'($urandom_range(255));
         crc  = crc_next(crc, data);
         send_byte(data);
      end
      if (length <= MAX_PAYLOAD) begin
         if (corrupt) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
         end
         send_byte(crc[15:8]);
         send_byte(crc[7:0]);
      end
   endtask

   // Stop offering bytes and wait until every expected beat has come, then let the
   // parser settle on bytes that give no result.
   task automatic wait_results_done();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (beats_pending != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index, input logic [BYTE_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // New sync bytes once every expected result has come; the spare indexes must change nothing.
   task automatic program_sync(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
      wait_results_done();
      csr_write(CSR_SYNC_FIRST, first);
      csr_write(CSR_SYNC_SECOND, second);
      csr_write(CSR_SPARE_LOW, 8'($urandom_range(255)));
      csr_write(CSR_SPARE_HIGH, 8'($urandom_range(255)));
      sync_first_val  = first;
      sync_second_val = second;
   endtask

   // Mostly well-formed frames with random content, plus broken syncs, cut headers,
   // line noise and the odd oversized frame.
   task automatic random_traffic(input int byte_goal);
      int               stop_at;
      int               pick;
      int               burst;
      logic [LEN_W-1:0] length;
      stop_at = sent_bytes + byte_goal;
      while (sent_bytes < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 74) begin
            length = ($urandom_range(3) == 0) ? 16'($urandom_range(40)) : 16'($urandom_range(6));
            send_frame(8'($urandom_range(255)), length, $urandom_range(4) == 0);
         end else if (pick < 82) begin
            send_byte(sync_first_val);
            send_byte(8'($urandom_range(255)));
         end else if (pick < 85) begin
            // The next frame's bytes are read as the rest of this header.
            send_byte(sync_first_val);
            send_byte(sync_second_val);
            burst = $urandom_range(2, 1);
            repeat (burst) send_byte(8'($urandom_range(255)));
         end else if (pick < 99) begin
            burst = $urandom_range(4, 1);
            repeat (burst) send_byte(8'($urandom_range(255)));
         end else begin
            length = 16'($urandom_range(65535, MAX_PAYLOAD + 1));
            send_frame(8'($urandom_range(255)), length, 1'b0);
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.rx_byte   = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      send_idle_pct    = 15;
      recv_idle_pct    = 62;
      hold_off_request = 1'b0;
      sent_bytes       = 0;
      sync_first_val   = SYNC_FIRST_RESET;
      sync_second_val  = SYNC_SECOND_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty frames good and bad, a repeated first sync, a one-byte frame.
      send_frame(8'h00, 16'h0000, 1'b0);
      send_byte(sync_first_val);
      send_byte(sync_first_val);
      send_byte(sync_second_val);
      send_frame(8'hFF, 16'h0001, 1'b0);
      send_frame(8'h5A, 16'h0000, 1'b1);

      // Sender seldom idle, receiver often; starts with an overflowing frame.
      program_sync(8'h00, 8'hFF);
      send_frame(8'($urandom_range(255)), 16'hFFFF, 1'b0);
      random_traffic(PHASE_BYTES);

      // Sender often idle, receiver seldom; starts with a frame filled to capacity.
      program_sync(8'hFF, 8'h00);
      send_idle_pct = 62;
      recv_idle_pct = 15;
      send_frame(8'($urandom_range(255)), 16'(MAX_PAYLOAD), 1'b0);
      random_traffic(PHASE_BYTES);

      // No idling; a long receiver hold-off fills the parser, then the sender pauses.
      program_sync(8'($urandom_range(255)), 8'($urandom_range(255)));
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      hold_off_request = 1'b1;
      send_frame(8'($urandom_range(255)), 16'd48, 1'b0);
      wait_results_done();
      random_traffic(PHASE_BYTES);

      wait_results_done();
      if (check_failures == 0 && beats_pending == 0) begin
         $display("** sync_length_crc_frame_parser: PASSED **");
      end else begin
         $display("** sync_length_crc_frame_parser: FAILED **");
      end
      $finish;
   end

endmodule
